[rtl/afk_pkg.sv]
// Package for the arm forward kinematics block: word types, CORDIC constants
// and register indexes. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package afk_pkg;

  localparam int CORDIC_STEPS = 18;
  localparam int CW = 34;

  // CORDIC start value for x: the inverse gain in Q2.30.
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30 = 34'sd1073741824;

  localparam logic [2:0] CFG_ROT_ROW_ZERO = 3'd0;
  localparam logic [2:0] CFG_ROT_ROW_ONE  = 3'd1;
  localparam logic [2:0] CFG_ROT_ROW_TWO  = 3'd2;
  localparam logic [2:0] CFG_SHIFT_X      = 3'd3;
  localparam logic [2:0] CFG_SHIFT_Y      = 3'd4;
  localparam logic [2:0] CFG_SHIFT_Z      = 3'd5;

  localparam logic [47:0] ROT_ROW_ZERO_RST = 48'd16384;
  localparam logic [47:0] ROT_ROW_ONE_RST  = 48'd1073741824;
  localparam logic [47:0] ROT_ROW_TWO_RST  = 48'd70368744177664;

  typedef struct packed {
    logic [15:0] angle_base;
    logic [15:0] angle_shoulder;
    logic [15:0] angle_wrist;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } out_word_t;

  // Arctangent of 2^-i, 2^32 units per turn.
  function automatic logic signed [CW-1:0] atan_val(input int idx);
    logic signed [CW-1:0] v;
    v = '0;
    case (idx)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679839;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/arm_forward_kinematics.sv]
// Forward position of a three-joint arm in the torso frame, fully pipelined.
// Depends on afk_pkg and afk_cordic.
//
//   channel  ports                          direction  flow
//   input    start, busy, in_data           in         word taken when start && !busy
//   result   out_valid, out_data            out        one-cycle strobe, no back-pressure
//   config   cfg_we, cfg_index, cfg_data    in         write on cfg_we, no wait
//
// A word is accepted in every cycle; busy is always low.
// The CORDIC pipeline has one stage per step plus entry and sign fix; the arm
// products, torso mapping and rounding follow in further registered stages.
// Reset clears the valid line and loads the identity rotation and zero shift.
// Nothing stalls: the receiver takes every result in its strobe cycle.
`timescale 1ns / 1ps
`default_nettype none
module arm_forward_kinematics (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire afk_pkg::in_word_t   in_data,
  output logic                     out_valid,
  output afk_pkg::out_word_t       out_data,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [47:0]         cfg_data
);

  localparam int LAT = 26;
  localparam int CW  = afk_pkg::CW;

  logic [LAT-1:0]     vld_r;
  logic [47:0]        rot0_r, rot1_r, rot2_r;
  logic signed [31:0] shx_r, shy_r, shz_r;

  logic signed [CW-1:0] c0, s0, c1, s1;
  logic signed [CW-1:0] c0_r, s0_r;
  logic signed [35:0]   u_r, v_r, u_nxt, v_nxt;
  logic signed [69:0]   cu_r, sv_r, su_r, cv_r;
  logic signed [37:0]   px_r, py_r, px_nxt, py_nxt;
  logic signed [53:0]   m0a_r, m0b_r, m1a_r, m1b_r, m2a_r, m2b_r;
  logic signed [33:0]   ax_r, ay_r, az_r;
  afk_pkg::out_word_t   out_r;

  afk_cordic u_cordic_base (
    .clk(clk), .angle(in_data.angle_base), .cos_val(c0), .sin_val(s0)
  );
  afk_cordic u_cordic_shoulder (
    .clk(clk), .angle(in_data.angle_shoulder), .cos_val(c1), .sin_val(s1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rot0_r <= afk_pkg::ROT_ROW_ZERO_RST;
      rot1_r <= afk_pkg::ROT_ROW_ONE_RST;
      rot2_r <= afk_pkg::ROT_ROW_TWO_RST;
      shx_r  <= '0;
      shy_r  <= '0;
      shz_r  <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
      if (cfg_we) begin
        unique case (cfg_index)
          afk_pkg::CFG_ROT_ROW_ZERO: rot0_r <= cfg_data;
          afk_pkg::CFG_ROT_ROW_ONE:  rot1_r <= cfg_data;
          afk_pkg::CFG_ROT_ROW_TWO:  rot2_r <= cfg_data;
          afk_pkg::CFG_SHIFT_X:      shx_r  <= cfg_data[31:0];
          afk_pkg::CFG_SHIFT_Y:      shy_r  <= cfg_data[31:0];
          afk_pkg::CFG_SHIFT_Z:      shz_r  <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
  end

  // Shoulder link: u = -1.5 sin(q1), v = 1.5 cos(q1) + 1, floored in Q.30.
  always_comb begin
    u_nxt = (-(36'(s1) * 36'sd3)) >>> 1;
    v_nxt = ((36'(c1) * 36'sd3) >>> 1) + 36'(afk_pkg::ONE_Q30);
  end

  always_ff @(posedge clk) begin
    u_r  <= u_nxt;
    v_r  <= v_nxt;
    c0_r <= c0;
    s0_r <= s0;
    cu_r <= 70'(c0_r) * 70'(u_r);
    sv_r <= 70'(s0_r) * 70'(v_r);
    su_r <= 70'(s0_r) * 70'(u_r);
    cv_r <= 70'(c0_r) * 70'(v_r);
  end

  always_comb begin
    px_nxt = 38'(cu_r >>> 30) - 38'(sv_r >>> 30);
    py_nxt = 38'(su_r >>> 30) + 38'(cv_r >>> 30);
  end

  always_ff @(posedge clk) begin
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    m0a_r <= 54'($signed(rot0_r[15:0]))  * 54'(px_r);
    m0b_r <= 54'($signed(rot0_r[31:16])) * 54'(py_r);
    m1a_r <= 54'($signed(rot1_r[15:0]))  * 54'(px_r);
    m1b_r <= 54'($signed(rot1_r[31:16])) * 54'(py_r);
    m2a_r <= 54'($signed(rot2_r[15:0]))  * 54'(px_r);
    m2b_r <= 54'($signed(rot2_r[31:16])) * 54'(py_r);
  end

  // Sum in Q.44 with the shift, round half up to Q.16.
  function automatic logic signed [33:0] map_sum(input logic signed [53:0] a,
                                                 input logic signed [53:0] b,
                                                 input logic signed [31:0] sh);
    logic signed [61:0] acc;
    acc = 62'(a) + 62'(b) + (62'(sh) <<< 28) + 62'sd134217728;
    return 34'(acc >>> 28);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] a);
    logic signed [31:0] r;
    if (a > 34'sd2147483647) r = 32'sh7FFFFFFF;
    else if (a < -34'sd2147483648) r = 32'sh80000000;
    else r = 32'(a);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    ax_r <= map_sum(m0a_r, m0b_r, shx_r);
    ay_r <= map_sum(m1a_r, m1b_r, shy_r);
    az_r <= map_sum(m2a_r, m2b_r, shz_r);
    out_r.pos_x <= sat32(ax_r);
    out_r.pos_y <= sat32(ay_r);
    out_r.pos_z <= sat32(az_r);
  end

  assign busy      = 1'b0;
  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_r;

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> vld_r[0]) else $error("accepted word did not enter the pipeline");
  a_travel: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |=> vld_r[1]) else $error("valid bit lost in the pipeline");
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result strobe right after reset");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !start |=> !vld_r[0]) else $error("word entered without start");

endmodule
`default_nettype wire

[rtl/afk_cordic.sv]
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, giving
// cosine and sine in Q2.30 of a 16-bit binary angle. Depends on afk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module afk_cordic (
  input  wire logic                              clk,
  input  wire logic [15:0]                       angle,
  output logic signed [afk_pkg::CW-1:0]          cos_val,
  output logic signed [afk_pkg::CW-1:0]          sin_val
);

  localparam int N = afk_pkg::CORDIC_STEPS;

  logic signed [afk_pkg::CW-1:0] x_r [0:N];
  logic signed [afk_pkg::CW-1:0] y_r [0:N];
  logic signed [afk_pkg::CW-1:0] z_r [0:N];
  logic                          flip_r [0:N];
  logic signed [afk_pkg::CW-1:0] cos_r;
  logic signed [afk_pkg::CW-1:0] sin_r;
  logic                          flip_nxt;
  logic [31:0]                   w_nxt;

  // Angles in the left half plane are turned by half a turn; the sign
  // of both results is restored at the end.
  always_comb begin
    flip_nxt = angle[15] ^ angle[14];
    w_nxt    = {angle[15] ^ flip_nxt, angle[14:0], 16'h0000};
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= afk_pkg::CORDIC_GAIN;
    y_r[0]    <= '0;
    z_r[0]    <= {{(afk_pkg::CW-32){w_nxt[31]}}, w_nxt};
    flip_r[0] <= flip_nxt;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!z_r[i][afk_pkg::CW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - afk_pkg::atan_val(i);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + afk_pkg::atan_val(i);
      end
      flip_r[i+1] <= flip_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (flip_r[N]) begin
      cos_r <= -x_r[N];
      sin_r <= -y_r[N];
    end else begin
      cos_r <= x_r[N];
      sin_r <= y_r[N];
    end
  end

  // The final angle residue is not needed.
  assign cos_val = cos_r;
  assign sin_val = sin_r;

endmodule
`default_nettype wire

[bench/arm_forward_kinematics_checker.sv]
// Checker for the arm forward kinematics block: mirrors the rotation and
// offset registers, predicts each position word and compares it with the
// block's output. Depends on afk_pkg.
`timescale 1ns / 1ps
module arm_forward_kinematics_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  afk_pkg::in_word_t           in_data,
  input  logic                        out_valid,
  input  afk_pkg::out_word_t          out_data,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [47:0]                 cfg_data,
  output int                          errors,
  output int                          pending
);

  logic [47:0]        row_x, row_y, row_z;
  logic [31:0]        off_x, off_y, off_z;
  afk_pkg::out_word_t pose_q[$];

  function automatic longint arctan_step(input int i);
    longint tab[18];
    tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679839, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215};
    return tab[i];
  endfunction

  // Rotation-mode CORDIC on a binary angle; cosine and sine in Q2.30.
  function automatic void sin_cos(input logic [15:0] ang, output longint c,
                                  output longint s);
    logic        flip;
    logic [31:0] w;
    longint      x, y, z, dx, dy;
    flip = ang >= 16'd16384 && ang < 16'd49152;
    w = {ang, 16'h0000};
    if (flip) w = w + 32'h8000_0000;
    z = longint'($signed(w));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 18; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - arctan_step(i);
      end else begin
        x = x + dx; y = y - dy; z = z + arctan_step(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] torso_coord(input logic [47:0] row, input logic [31:0] off,
                                              input longint px, input longint py);
    longint acc;
    acc = longint'($signed(row[15:0])) * px + longint'($signed(row[31:16])) * py;
    acc = acc + longint'($signed(off)) * 268435456;
    acc = (acc + 134217728) >>> 28;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  function automatic afk_pkg::out_word_t arm_pose(input afk_pkg::in_word_t w);
    longint             c0, s0, c1, s1, u, v, px, py;
    afk_pkg::out_word_t p;
    sin_cos(w.angle_base, c0, s0);
    sin_cos(w.angle_shoulder, c1, s1);
    u = (-3 * s1) >>> 1;
    v = ((3 * c1) >>> 1) + 1073741824;
    px = ((c0 * u) >>> 30) - ((s0 * v) >>> 30);
    py = ((s0 * u) >>> 30) + ((c0 * v) >>> 30);
    p.pos_x = torso_coord(row_x, off_x, px, py);
    p.pos_y = torso_coord(row_y, off_y, px, py);
    p.pos_z = torso_coord(row_z, off_z, px, py);
    return p;
  endfunction

  assign pending = pose_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    afk_pkg::out_word_t exp_w;
    int                 bad;
    bad = 0;
    if (!rst_n) begin
      row_x <= afk_pkg::ROT_ROW_ZERO_RST;
      row_y <= afk_pkg::ROT_ROW_ONE_RST;
      row_z <= afk_pkg::ROT_ROW_TWO_RST;
      off_x <= '0;
      off_y <= '0;
      off_z <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          afk_pkg::CFG_ROT_ROW_ZERO: row_x <= cfg_data;
          afk_pkg::CFG_ROT_ROW_ONE:  row_y <= cfg_data;
          afk_pkg::CFG_ROT_ROW_TWO:  row_z <= cfg_data;
          afk_pkg::CFG_SHIFT_X:      off_x <= cfg_data[31:0];
          afk_pkg::CFG_SHIFT_Y:      off_y <= cfg_data[31:0];
          afk_pkg::CFG_SHIFT_Z:      off_z <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (start && !busy) pose_q.push_back(arm_pose(in_data));
      if (out_valid) begin
        if (pose_q.size() == 0) begin
          $error("position word with none expected");
          bad = bad + 1;
        end else begin
          exp_w = pose_q.pop_front();
          if (out_data.pos_x !== exp_w.pos_x) begin
            $error("pos_x: expected %0d, got %0d", exp_w.pos_x, out_data.pos_x);
            bad = bad + 1;
          end
          if (out_data.pos_y !== exp_w.pos_y) begin
            $error("pos_y: expected %0d, got %0d", exp_w.pos_y, out_data.pos_y);
            bad = bad + 1;
          end
          if (out_data.pos_z !== exp_w.pos_z) begin
            $error("pos_z: expected %0d, got %0d", exp_w.pos_z, out_data.pos_z);
            bad = bad + 1;
          end
        end
      end
      if (bad != 0) errors <= errors + bad;
    end
  end
endmodule

[bench/arm_forward_kinematics_test.sv]
// Top of the arm forward kinematics bench: clock, reset, angle, rotation and
// offset stimulus, and the verdict. Depends on afk_pkg, the block and its checker.
`timescale 1ns / 1ps
module arm_forward_kinematics_test;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  afk_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  afk_pkg::out_word_t out_data;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [47:0]        cfg_data = '0;
  int                 errors, pending;
  int                 idle_pct = 0;
  int                 cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  arm_forward_kinematics u_top (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  arm_forward_kinematics_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_index, .cfg_data, .errors, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // Called on a rising edge; returns on the edge at which the word is taken.
  task automatic send_angles(input afk_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random();
    afk_pkg::in_word_t w;
    w = afk_pkg::in_word_t'(48'({$urandom, $urandom}));
    send_angles(w);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [47:0] r0, r1, r2, input logic [47:0] sx, sy, sz);
    write_reg(afk_pkg::CFG_ROT_ROW_ZERO, r0);
    write_reg(afk_pkg::CFG_ROT_ROW_ONE, r1);
    write_reg(afk_pkg::CFG_ROT_ROW_TWO, r2);
    write_reg(afk_pkg::CFG_SHIFT_X, sx);
    write_reg(afk_pkg::CFG_SHIFT_Y, sy);
    write_reg(afk_pkg::CFG_SHIFT_Z, sz);
  endtask

  initial begin
    logic [15:0] corner[10];
    corner = '{16'd0, 16'd16383, 16'd16384, 16'd32768, 16'd49151, 16'd49152,
               16'd65535, 16'd8192, 16'd24576, 16'd40960};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fold boundaries of both joints, wrist extremes, default offset.
    for (int i = 0; i < 10; i++) send_angles('{corner[i], corner[(i * 3) % 10], 16'd0});
    for (int i = 0; i < 10; i++) send_angles('{corner[(i * 7) % 10], corner[i], 16'hFFFF});

    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        1: write_all({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
                     {16'hFFFF, 32'h7FFF_FFFF}, 48'h7FFF_FFFF, 48'h7FFF_FFFF);
        2: write_all({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                     48'h8000_0000, {16'hABCD, 32'h8000_0000}, 48'h8000_0000);
        3: begin
          write_all(rand48(), rand48(), rand48(), rand48(), rand48(), rand48());
          // Indexes past the last register must leave the offset alone.
          write_reg(3'd6, rand48());
          write_reg(3'd7, rand48());
        end
        4: write_all(48'd16384, 48'd1073741824, 48'd70368744177664,
                     48'h7FFF_0000, 48'h8001_0000, 48'h0000_8000);
        5: write_all(rand48(), rand48(), rand48(), rand48(), rand48(), rand48());
        default: ;
      endcase
      cfg_we <= 1'b0;
      idle_pct = (phase == 1 || phase == 4) ? 83 : (phase == 5) ? 30 : 0;
      for (int n = 0; n < 180; n++) begin
        send_random();
        if (n == 90 && phase == 3) wait_drained();
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/afk_pkg.sv
rtl/afk_cordic.sv
rtl/arm_forward_kinematics.sv
bench/arm_forward_kinematics_checker.sv
bench/arm_forward_kinematics_test.sv
